// File: hdl/rlp_pkg.sv
// rlp_pkg: shared types and constants for the integer run-length packer.
// Used by rlp_front, rlp_cmd_fifo, rlp_back and integer_run_length_packer_core.
package rlp_pkg;

  localparam int BUF_DEPTH_DEF = 32;
  localparam int CMD_DEPTH     = 4;
  localparam int WORD_W        = 32;
  localparam int COUNT_W       = 31;

  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     last_of_item;
  } out_item_t;

  // One group to emit: a run (count, value) or a literal read from a store bank.
  typedef struct packed {
    logic                     is_run;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] value;
    logic                     bank;
  } cmd_t;

  typedef struct packed {
    logic                     we;
    logic                     bank;
    logic signed [WORD_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic done;
    logic bank;
  } lit_done_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_HEAD,
    B_RUNV,
    B_LIT
  } back_state_t;

endpackage

// File: hdl/integer_run_length_packer_core.sv
// Path: a group closed by an input transfer passes the command queue, the back end's idle
// dispatch state and the output register, then one word per cycle while out_stall is low.
// Throughput: one input transfer per cycle; input also stalls after a full-store flush.
// Input stalls while the command queue is full, and a literal flush stalls input while the
// other store bank is still being drained.
// Reset (rst_n, synchronous): clears group state, queue and output valid; store contents
// stay undefined and need no clearing pass.
module integer_run_length_packer_core #(
  parameter int BUF_DEPTH = rlp_pkg::BUF_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rlp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rlp_pkg::out_item_t out_data
);
  import rlp_pkg::*;

  localparam int IDXW = $clog2(BUF_DEPTH);

  logic            push;
  cmd_t            push_cmd;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  cmd_t            q_cmd;
  lit_done_t       lit_done;
  wr_t             wr;
  logic [IDXW-1:0] wr_idx;

  rlp_front #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .lit_done (lit_done),
    .wr       (wr),
    .wr_idx   (wr_idx)
  );

  rlp_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  rlp_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .wr        (wr),
    .wr_idx    (wr_idx),
    .lit_done  (lit_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hdl/rlp_front.sv
// rlp_front: accepts items, tracks the pending group and issues emit commands.
// Writes literal values into the double-banked store held in rlp_back.
// Depends on rlp_pkg.
module rlp_front #(
  parameter int BUF_DEPTH = rlp_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rlp_pkg::in_item_t            in_data,
  output logic                         push,
  output rlp_pkg::cmd_t                push_cmd,
  input  logic                         q_full,
  input  rlp_pkg::lit_done_t           lit_done,
  output rlp_pkg::wr_t                 wr,
  output logic [$clog2(BUF_DEPTH)-1:0] wr_idx
);
  import rlp_pkg::*;

  localparam int IDXW = $clog2(BUF_DEPTH);
  localparam logic [IDXW-1:0] IDX_FULL = IDXW'(BUF_DEPTH - 1);

  logic [COUNT_W-1:0]       held_r, held_nxt;
  logic [IDXW-1:0]          widx_r, widx_nxt;
  logic                     run_r, run_nxt;
  logic signed [WORD_W-1:0] first_r, first_nxt;
  logic signed [WORD_W-1:0] last_r, last_nxt;
  logic                     bank_r, bank_nxt;
  logic [1:0]               busy_r, busy_nxt;
  logic                     pend2_r, pend2_nxt;

  logic                     accept;
  logic                     is_end;
  logic signed [WORD_W-1:0] v;
  logic                     rep;
  logic                     held_zero;
  logic                     held_one;
  logic                     held_max;
  logic                     lit_full;
  logic                     flush_run;
  logic                     flush_lit;

  always_comb begin
    v         = in_data.value;
    is_end    = (in_data.kind == KIND_END);
    rep       = (last_r == v);
    held_zero = (held_r == '0);
    held_one  = (held_r == COUNT_W'(1));
    held_max  = &held_r;
    lit_full  = (widx_r == IDX_FULL);
    if (is_end) begin
      flush_lit = !held_zero && (!run_r || held_one);
      flush_run = run_r && !held_zero && !held_one;
    end else begin
      flush_lit = !held_zero && !held_one && !run_r && (rep || lit_full);
      flush_run = !held_zero && !held_one && run_r && (!rep || held_max);
    end
    in_stall = pend2_r || q_full || (flush_lit && busy_r[~bank_r]);
    accept   = in_valid && !in_stall;
  end

  always_comb begin
    held_nxt  = held_r;
    widx_nxt  = widx_r;
    run_nxt   = run_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r;
    pend2_nxt = 1'b0;
    wr.we     = 1'b0;
    wr.bank   = bank_r;
    wr.data   = v;
    wr_idx    = '0;
    push      = 1'b0;

    push_cmd.is_run = flush_run;
    push_cmd.count  = (flush_lit && !is_end) ? (held_r - COUNT_W'(1)) : held_r;
    push_cmd.value  = first_r;
    push_cmd.bank   = bank_r;

    if (lit_done.done) begin
      busy_nxt[lit_done.bank] = 1'b0;
    end

    if (pend2_r) begin
      // second slot of a new literal after a full-store flush
      wr.we   = 1'b1;
      wr_idx  = IDXW'(1);
      wr.data = last_r;
    end else if (accept) begin
      push = flush_run || flush_lit;
      if (flush_lit) begin
        bank_nxt         = ~bank_r;
        busy_nxt[bank_r] = 1'b1;
      end
      if (is_end) begin
        held_nxt = '0;
        widx_nxt = '0;
        run_nxt  = 1'b0;
      end else if (held_zero) begin
        wr.we     = 1'b1;
        first_nxt = v;
        last_nxt  = v;
        held_nxt  = COUNT_W'(1);
        widx_nxt  = IDXW'(1);
        run_nxt   = 1'b0;
      end else if (held_one) begin
        last_nxt = v;
        held_nxt = COUNT_W'(2);
        if (rep) begin
          run_nxt  = 1'b1;
          widx_nxt = IDXW'(1);
        end else begin
          wr.we    = 1'b1;
          wr_idx   = IDXW'(1);
          widx_nxt = IDXW'(2);
        end
      end else if (flush_run) begin
        wr.we     = 1'b1;
        first_nxt = v;
        last_nxt  = v;
        held_nxt  = COUNT_W'(1);
        widx_nxt  = IDXW'(1);
        run_nxt   = 1'b0;
      end else if (flush_lit) begin
        wr.we     = 1'b1;
        wr.bank   = ~bank_r;
        wr.data   = last_r;
        first_nxt = last_r;
        held_nxt  = COUNT_W'(2);
        if (rep) begin
          run_nxt  = 1'b1;
          widx_nxt = IDXW'(1);
        end else begin
          pend2_nxt = 1'b1;
          last_nxt  = v;
          widx_nxt  = IDXW'(2);
          run_nxt   = 1'b0;
        end
      end else begin
        held_nxt = held_r + COUNT_W'(1);
        last_nxt = v;
        if (!run_r) begin
          wr.we    = 1'b1;
          wr_idx   = widx_r;
          widx_nxt = widx_r + IDXW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      widx_r  <= '0;
      run_r   <= 1'b0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
      pend2_r <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      widx_r  <= widx_nxt;
      run_r   <= run_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
      pend2_r <= pend2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

  a_cur_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r[bank_r])
    else $error("front is filling a bank that is still being drained");

  a_lit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!run_r && held_r != '0) |-> (held_r == COUNT_W'(widx_r)))
    else $error("literal count and write index disagree");

  a_pend_once: assert property (@(posedge clk) disable iff (!rst_n)
    pend2_r |=> !pend2_r)
    else $error("second write pending for more than one cycle");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command pushed into full queue");

endmodule

// File: hdl/rlp_cmd_fifo.sv
// rlp_cmd_fifo: short command queue between rlp_front and rlp_back.
// Depends on rlp_pkg.
module rlp_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rlp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output rlp_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import rlp_pkg::*;

  localparam int AW = $clog2(CMD_DEPTH);

  cmd_t        slots_r [CMD_DEPTH];
  logic [AW:0] wptr_r, wptr_nxt;
  logic [AW:0] rptr_r, rptr_nxt;

  always_comb begin
    empty    = (wptr_r == rptr_r);
    full     = (wptr_r[AW] != rptr_r[AW]) && (wptr_r[AW-1:0] == rptr_r[AW-1:0]);
    pop_cmd  = slots_r[rptr_r[AW-1:0]];
    wptr_nxt = push ? wptr_r + (AW+1)'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + (AW+1)'(1) : rptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r[AW-1:0]] <= push_cmd;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_push_nonfull: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full)
    else $error("push into full queue");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty)
    else $error("queue empty after push");

endmodule

// File: hdl/rlp_back.sv
// rlp_back: holds the two-bank literal store and emits result words per command.
// Output register on the result channel. Depends on rlp_pkg.
module rlp_back #(
  parameter int BUF_DEPTH = rlp_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  rlp_pkg::cmd_t                q_cmd,
  input  rlp_pkg::wr_t                 wr,
  input  logic [$clog2(BUF_DEPTH)-1:0] wr_idx,
  output rlp_pkg::lit_done_t           lit_done,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rlp_pkg::out_item_t           out_data
);
  import rlp_pkg::*;

  localparam int IDXW = $clog2(BUF_DEPTH);

  logic signed [WORD_W-1:0] mem_r [2][BUF_DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  back_state_t     state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic            out_valid_r;
  out_item_t       out_data_r, out_nxt;

  logic                     load_ok;
  logic                     out_load;
  logic                     rd_en;
  logic [IDXW-1:0]          rd_idx;
  logic [IDXW-1:0]          last_idx;
  logic signed [WORD_W-1:0] header;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.bank][wr_idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[cmd_r.bank][rd_idx];
    end
  end

  always_comb begin
    load_ok  = !out_valid_r || !out_stall;
    last_idx = cmd_r.count[IDXW-1:0] - IDXW'(1);
    header   = cmd_r.is_run ? {1'b0, cmd_r.count}
                            : WORD_W'(0) - {1'b0, cmd_r.count};

    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_idx        = idx_r;
    out_load      = 1'b0;
    out_nxt       = out_data_r;
    lit_done.done = 1'b0;
    lit_done.bank = cmd_r.bank;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = B_HEAD;
        end
      end
      B_HEAD: begin
        if (load_ok) begin
          out_load             = 1'b1;
          out_nxt.word         = header;
          out_nxt.last_of_item = 1'b0;
          if (cmd_r.is_run) begin
            state_nxt = B_RUNV;
          end else begin
            rd_en     = 1'b1;
            rd_idx    = '0;
            idx_nxt   = '0;
            state_nxt = B_LIT;
          end
        end
      end
      B_RUNV: begin
        if (load_ok) begin
          out_load             = 1'b1;
          out_nxt.word         = cmd_r.value;
          out_nxt.last_of_item = 1'b1;
          state_nxt            = B_IDLE;
        end
      end
      B_LIT: begin
        if (load_ok) begin
          out_load     = 1'b1;
          out_nxt.word = rd_data_r;
          if (idx_r == last_idx) begin
            out_nxt.last_of_item = 1'b1;
            lit_done.done        = 1'b1;
            state_nxt            = B_IDLE;
          end else begin
            out_nxt.last_of_item = 1'b0;
            rd_en                = 1'b1;
            rd_idx               = idx_r + IDXW'(1);
            idx_nxt              = idx_r + IDXW'(1);
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_lit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_LIT) |-> (idx_r <= last_idx))
    else $error("literal read index past group end");

  a_lit_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_LIT) |-> (!cmd_r.is_run && cmd_r.count != '0))
    else $error("literal drain with a run or empty command");

  a_runv_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUNV) |-> cmd_r.is_run)
    else $error("run value state with literal command");

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for integer_run_length_packer_core.
// Depends on rlp_pkg. A queue-fed driver and a monitor check every output word against an
// in-bench prediction: a count header before a run value, a negated count before literals.
module tb;
  import rlp_pkg::*;

  localparam int BUF_DEPTH  = BUF_DEPTH_DEF;
  localparam int N_ITEMS    = 410;
  localparam int QUIET_TAIL = 50;
  localparam int LIMIT      = 900000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  integer_run_length_packer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  in_item_t    pending_items[$];
  out_item_t   exp_words[$];
  out_item_t   step_words[$];

  // packer state as seen by the predictor
  logic [31:0] lit_store[BUF_DEPTH];
  logic [30:0] held_cnt = '0;
  int unsigned wr_idx = 0;
  bit          run_mode = 1'b0;

  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          n_items = 0;
  int          n_ends = 0;
  int          n_words = 0;
  int          gap_left = 0;
  int          gap_rate = 2;
  int          stall_left = 0;
  int          stall_rate = 2;

  function automatic void push_word(logic [31:0] w);
    out_item_t o;
    o.word         = w;
    o.last_of_item = 1'b0;
    step_words.push_back(o);
  endfunction

  function automatic void emit_run(logic [30:0] cnt, logic [31:0] v);
    push_word({1'b0, cnt});
    push_word(v);
  endfunction

  function automatic void emit_literal(logic [30:0] cnt);
    int unsigned c;
    c = (cnt > BUF_DEPTH) ? BUF_DEPTH : cnt;
    push_word(32'd0 - c);
    for (int i = 0; i < c; i++) push_word(lit_store[i]);
  endfunction

  function automatic int unsigned clip_slot(int unsigned i);
    return (i < BUF_DEPTH) ? i : BUF_DEPTH - 1;
  endfunction

  function automatic void predict_pack(in_item_t it);
    logic [31:0] v;
    int unsigned wi;
    int unsigned pi;
    bit          rep;
    v = it.value;
    step_words.delete();
    if (it.kind == KIND_END) begin
      if (held_cnt == 1 || (held_cnt > 1 && !run_mode)) emit_literal(held_cnt);
      else if (held_cnt > 1) emit_run(held_cnt, lit_store[0]);
      held_cnt = '0;
      wr_idx   = 0;
      run_mode = 1'b0;
    end else if (held_cnt == 0) begin
      lit_store[0] = v;
      held_cnt     = 31'd1;
      wr_idx       = 1;
      run_mode     = 1'b0;
    end else if (held_cnt == 1) begin
      rep          = (lit_store[0] == v);
      lit_store[1] = v;
      run_mode     = rep;
      wr_idx       = rep ? 1 : 2;
      held_cnt     = 31'd2;
    end else begin
      wi  = clip_slot(wr_idx);
      pi  = clip_slot(wi == 0 ? 0 : wi - 1);
      rep = (lit_store[pi] == v);
      lit_store[wi] = v;
      if (run_mode && (!rep || held_cnt == '1)) begin
        emit_run(held_cnt, lit_store[0]);
        lit_store[0] = v;
        held_cnt     = 31'd1;
        wr_idx       = 1;
        run_mode     = 1'b0;
      end else if ((!run_mode && rep) || wi == BUF_DEPTH - 1) begin
        emit_literal(held_cnt - 31'd1);
        lit_store[0] = lit_store[pi];
        held_cnt     = 31'd2;
        if (!rep) begin
          lit_store[1] = v;
          wr_idx       = 2;
        end else begin
          wr_idx   = 1;
          run_mode = 1'b1;
        end
      end else begin
        held_cnt = held_cnt + 31'd1;
        if (!run_mode) wr_idx = clip_slot(wi + 1);
      end
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last_of_item = 1'b1;
    foreach (step_words[i]) exp_words.push_back(step_words[i]);
  endfunction

  function automatic void add_value(logic [31:0] v);
    in_item_t it;
    it.kind  = KIND_VALUE;
    it.value = v;
    pending_items.push_back(it);
  endfunction

  function automatic void add_end();
    in_item_t it;
    it.kind  = KIND_END;
    it.value = $urandom;
    pending_items.push_back(it);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // distinct neighbors, so the group stays literal until the store fills
  function automatic void add_literal(int len);
    logic [31:0] prev;
    logic [31:0] v;
    prev = $urandom;
    for (int i = 0; i < len; i++) begin
      v = pick_value();
      while (v == prev) v = $urandom;
      add_value(v);
      prev = v;
    end
  endfunction

  function automatic void add_run(int len);
    logic [31:0] v;
    v = pick_value();
    for (int i = 0; i < len; i++) add_value(v);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pack(in_data);
        n_items++;
        if (in_data.kind == KIND_END) n_ends++;
      end
      if (cycle_cnt % 280 == 0) gap_rate = $urandom_range(0, 3);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_items.size() > QUIET_TAIL &&
                     $urandom_range(0, 15) < gap_rate) begin
          gap_left = $urandom_range(1, 19) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_words++;
        if (exp_words.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, expected none, actual word %0d last %0b",
                   $realtime, out_data.word, out_data.last_of_item);
        end else begin
          if (out_data !== exp_words[0]) begin
            err_cnt++;
            $display("%0t: mismatch, expected word %0d last %0b, actual word %0d last %0b",
                     $realtime, exp_words[0].word, exp_words[0].last_of_item,
                     out_data.word, out_data.last_of_item);
          end
          void'(exp_words.pop_front());
        end
      end
      if (cycle_cnt % 310 == 0) stall_rate = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (pending_items.size() > QUIET_TAIL &&
                   $urandom_range(0, 15) < stall_rate) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_cnt, exp_words.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // directed: empty end, single value, runs, run broken, repeat in literal
    add_end();
    add_value(32'h7fff_ffff);
    add_end();
    add_run(3);
    add_end();
    add_value(32'd5);
    add_value(32'd5);
    add_value(32'd6);
    add_end();
    add_value(32'd1);
    add_value(32'd2);
    add_value(32'd3);
    add_value(32'd3);
    add_end();
    add_value(32'h0000_0000);
    add_value(32'hffff_ffff);
    add_end();
    add_value(32'h8000_0000);
    add_value(32'h8000_0000);
    add_end();
    // random: start with store-full flushes back to back
    add_literal(33);
    add_literal(40);
    add_end();
    while (pending_items.size() < N_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_run(($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(2, 12));
        3, 4:    add_literal(($urandom_range(0, 3) == 0) ? $urandom_range(25, 40)
                                                         : $urandom_range(1, 8));
        5: begin
          for (int i = $urandom_range(4, 16); i > 0; i--) begin
            case ($urandom_range(0, 3))
              0: add_value(32'd0);
              1: add_value(32'd1);
              2: add_value(32'hffff_ffff);
              default: add_value(32'h8000_0000);
            endcase
          end
        end
        6: add_end();
        7: begin
          add_end();
          add_end();
        end
        default: begin
          add_literal($urandom_range(2, 6));
          add_value(pending_items[pending_items.size()-1].value);
        end
      endcase
    end
    add_end();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
    while (exp_words.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Packed %0d input items (%0d end markers) into %0d checked output words",
             n_items, n_ends, n_words);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rlp_pkg.sv
hdl/rlp_front.sv
hdl/rlp_cmd_fifo.sv
hdl/rlp_back.sv
hdl/integer_run_length_packer_core.sv
dv/tb.sv
